// ===== rtl/core/biquad_iir_filter_defines.svh =====
// Assertion macros used by the checker file
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BQF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqf assertion failed");

// Next-cycle implication, disabled during reset
`define BQF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqf assertion failed");

`endif

// ===== rtl/core/bqf_pkg.sv =====
package bqf_pkg;

   // Sample and coefficient formats
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = COEF_W - 5;

   // Accumulator holds five exact products
   localparam int ACC_W  = SAMPLE_W + COEF_W + 3;
   // Rounded sum, before scaling by the reciprocal of a0
   localparam int T_W    = ACC_W - COEF_FRAC;
   // Shared multiplier operand and product widths
   localparam int OP_W   = (T_W > COEF_W) ? T_W : COEF_W;
   localparam int PROD_W = 2 * OP_W;
   localparam int RND_W  = PROD_W + 1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_B0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_A0 = 3'd5;

   // Request action codes
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // Coefficient set
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] inv_a0;
   } coef_type;

   // Product terms of the difference equation
   localparam int TAP_W = 3;
   typedef enum logic [TAP_W-1:0] {
      TAP_B0 = 3'd0,
      TAP_B1 = 3'd1,
      TAP_B2 = 3'd2,
      TAP_A1 = 3'd3,
      TAP_A2 = 3'd4
   } tap_type;

   // Controller states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MAC    = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_ROUND  = 6'b001000,
      ST_SCALE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic    load;      // capture sample, clear accumulator
      logic    clear;     // zero the histories
      logic    issue;     // multiply one tap
      tap_type tap;
      logic    acc_en;    // fold last product into the accumulator
      logic    round_en;  // round the sum to sample steps
      logic    scale_en;  // multiply by reciprocal of a0
      logic    commit;    // clamp, write result, shift histories
   } cmd_type;

endpackage

// ===== rtl/core/bqf_csr.sv =====
module bqf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]       csr_data,
   output bqf_pkg::coef_type                coef
);
   import bqf_pkg::*;

   coef_type coef_ff, coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   // Decode the write; drop unknown indexes
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_B0:     coef_in.b0     = csr_data;
            CSR_B1:     coef_in.b1     = csr_data;
            CSR_B2:     coef_in.b2     = csr_data;
            CSR_A1:     coef_in.a1     = csr_data;
            CSR_A2:     coef_in.a2     = csr_data;
            CSR_INV_A0: coef_in.inv_a0 = csr_data;
            default:    coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0     <= COEF_W'(1) << COEF_FRAC;
         coef_ff.b1     <= '0;
         coef_ff.b2     <= '0;
         coef_ff.a1     <= '0;
         coef_ff.a2     <= '0;
         coef_ff.inv_a0 <= COEF_W'(1) << COEF_FRAC;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== rtl/core/bqf_ctrl.sv =====
module bqf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqf_pkg::cmd_type cmd
);
   import bqf_pkg::*;

   state_type state_ff, state_in;
   tap_type   tap_ff, tap_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Clear, or step a word through five products, round, scale, commit
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      cmd      = '0;
      cmd.tap  = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  tap_in   = TAP_B0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.issue  = 1'b1;
            cmd.acc_en = (tap_ff != TAP_B0);
            if (tap_ff == TAP_A2) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_type'(TAP_W'(tap_ff) + TAP_W'(1));
            end
         end
         ST_DRAIN: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Raise valid on commit, drop it when the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= TAP_B0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/bqf_dp.sv =====
module bqf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  bqf_pkg::coef_type                   coef,
   input  bqf_pkg::cmd_type                    cmd,
   output logic signed [bqf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_saturated
);
   import bqf_pkg::*;

   localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W+1)'(1) << (COEF_FRAC - 1);
   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(SAMPLE_MAX);
   localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(SAMPLE_MIN);

   // Histories
   logic signed [SAMPLE_W-1:0] xd1_ff, xd1_in, xd2_ff, xd2_in;
   logic signed [SAMPLE_W-1:0] yd1_ff, yd1_in, yd2_ff, yd2_in;
   // Working registers
   logic signed [SAMPLE_W-1:0] x0_ff;
   logic signed [PROD_W-1:0]   p_ff;
   logic                       p_neg_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [T_W-1:0]      t_ff;
   logic signed [SAMPLE_W-1:0] out_ff;
   logic                       sat_ff;

   logic signed [OP_W-1:0]     op_a, op_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    p_acc, acc_sum;
   logic signed [ACC_W:0]      acc_rnd;
   logic signed [T_W-1:0]      t_in;
   logic signed [RND_W-1:0]    p_rnd, r_wide;
   logic signed [SAMPLE_W-1:0] r_clamp;
   logic                       r_sat;

   assign rsp_sample_out = out_ff;
   assign rsp_saturated  = sat_ff;

   // Select multiplier operands
   always_comb begin
      op_a = OP_W'(coef.inv_a0);
      op_b = OP_W'(t_ff);
      if (cmd.issue) begin
         case (cmd.tap)
            TAP_B0: begin op_a = OP_W'(coef.b0); op_b = OP_W'(x0_ff);  end
            TAP_B1: begin op_a = OP_W'(coef.b1); op_b = OP_W'(xd1_ff); end
            TAP_B2: begin op_a = OP_W'(coef.b2); op_b = OP_W'(xd2_ff); end
            TAP_A1: begin op_a = OP_W'(coef.a1); op_b = OP_W'(yd1_ff); end
            TAP_A2: begin op_a = OP_W'(coef.a2); op_b = OP_W'(yd2_ff); end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end

   assign prod = op_a * op_b;

   // Accumulate; feedback terms subtract
   assign p_acc   = p_ff[ACC_W-1:0];
   assign acc_sum = p_neg_ff ? (acc_ff - p_acc) : (acc_ff + p_acc);

   // Round the sum to sample steps, ties up
   assign acc_rnd = (ACC_W+1)'(acc_ff) + ACC_HALF;
   assign t_in    = acc_rnd[COEF_FRAC +: T_W];

   // Round the scaled value and clamp to the sample range
   assign p_rnd  = RND_W'(p_ff) + RND_HALF;
   assign r_wide = p_rnd >>> COEF_FRAC;

   always_comb begin
      r_sat   = 1'b0;
      r_clamp = r_wide[SAMPLE_W-1:0];
      if (r_wide > RND_MAX) begin
         r_clamp = SAMPLE_MAX;
         r_sat   = 1'b1;
      end else if (r_wide < RND_MIN) begin
         r_clamp = SAMPLE_MIN;
         r_sat   = 1'b1;
      end
   end

   // Shift or clear the histories
   always_comb begin
      xd1_in = xd1_ff;
      xd2_in = xd2_ff;
      yd1_in = yd1_ff;
      yd2_in = yd2_ff;
      if (cmd.clear) begin
         xd1_in = '0;
         xd2_in = '0;
         yd1_in = '0;
         yd2_in = '0;
      end else if (cmd.commit) begin
         xd2_in = xd1_ff;
         xd1_in = x0_ff;
         yd2_in = yd1_ff;
         yd1_in = r_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xd1_ff <= '0;
         xd2_ff <= '0;
         yd1_ff <= '0;
         yd2_ff <= '0;
      end else begin
         xd1_ff <= xd1_in;
         xd2_ff <= xd2_in;
         yd1_ff <= yd1_in;
         yd2_ff <= yd2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff  <= req_sample_in;
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_sum;
      end
      if (cmd.issue || cmd.scale_en) begin
         p_ff     <= prod;
         p_neg_ff <= cmd.issue && ((cmd.tap == TAP_A1) || (cmd.tap == TAP_A2));
      end
      if (cmd.round_en) begin
         t_ff <= t_in;
      end
      if (cmd.commit) begin
         out_ff <= r_clamp;
         sat_ff <= r_sat;
      end
   end

endmodule

// ===== rtl/core/biquad_iir_filter.sv =====
// A filtered word runs through the states MAC, DRAIN, ROUND, SCALE and
// FINISH, which holds while the last result waits. No new sample is taken
// until it is done, as six products share one 32x32 multiplier, plus the
// accumulate, round, scale and clamp steps. A clear word gives no result.
// Reset (synchronous, active high) zeroes the histories, sets b0 and inv_a0
// to 1.0 and the other coefficients to zero.
module biquad_iir_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bqf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]          csr_data
);
   import bqf_pkg::*;

   coef_type coef;
   cmd_type  cmd;

   bqf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   bqf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   bqf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_sample_in  (req_sample_in),
      .coef           (coef),
      .cmd            (cmd),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== rtl/core/bqf_checker.sv =====
`include "biquad_iir_filter_defines.svh"

module bqf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_action,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [bqf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic                                rsp_saturated
);
   import bqf_pkg::*;

   logic              filter_fire, clear_fire, rsp_stall, at_limit;
   logic [SAMPLE_W:0] rsp_word;

   assign filter_fire = req_valid && req_ready && (req_action == ACT_FILTER);
   assign clear_fire  = req_valid && req_ready && (req_action == ACT_CLEAR);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_sample_out, rsp_saturated};
   assign at_limit    = (rsp_sample_out == SAMPLE_MAX) || (rsp_sample_out == SAMPLE_MIN);

   // A stalled result word holds
   `BQF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // A filter word keeps the block busy in the next cycle
   `BQF_ASSERT_NEXT(a_busy_after_filter, clock, reset, filter_fire, !req_ready)

   // A clear word finishes at once
   `BQF_ASSERT_NEXT(a_clear_one_cycle, clock, reset, clear_fire, req_ready)

   // A clipped word sits on a range limit
   `BQF_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, at_limit)

endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (.*);

// ===== sim/biquad_output_checker.sv =====
`timescale 1ns / 100ps

module biquad_output_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [bqf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                rsp_saturated,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bqf_pkg::COEF_W-1:0]          csr_data,
   output int                                  pending,
   output int                                  mismatches
);
   import bqf_pkg::*;

   // Wide enough for every exact product and sum in the filter
   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       saturated;
   } filtered_word_type;

   localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1) << COEF_FRAC;
   localparam wide_type ROUND_HALF = wide_type'(1) <<< (COEF_FRAC - 1);
   localparam wide_type HI_LIMIT   = wide_type'(SAMPLE_MAX);
   localparam wide_type LO_LIMIT   = wide_type'(SAMPLE_MIN);

   coef_type                   taps;
   logic signed [SAMPLE_W-1:0] x_hist1, x_hist2, y_hist1, y_hist2;
   filtered_word_type          expected_words[$];

   // Log one mismatch and count it
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns checker: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Direct form I step: exact sum, round, scale by 1/a0, round, clamp
   function automatic filtered_word_type filter_sample(input logic signed [SAMPLE_W-1:0] x0);
      wide_type          acc;
      wide_type          scaled;
      filtered_word_type word;
      acc = wide_type'($signed(taps.b0)) * wide_type'(x0)
          + wide_type'($signed(taps.b1)) * wide_type'(x_hist1)
          + wide_type'($signed(taps.b2)) * wide_type'(x_hist2)
          - wide_type'($signed(taps.a1)) * wide_type'(y_hist1)
          - wide_type'($signed(taps.a2)) * wide_type'(y_hist2);
      acc = (acc + ROUND_HALF) >>> COEF_FRAC;
      scaled = (acc * wide_type'($signed(taps.inv_a0)) + ROUND_HALF) >>> COEF_FRAC;
      word.saturated = 1'b1;
      if (scaled > HI_LIMIT) begin
         scaled = HI_LIMIT;
      end else if (scaled < LO_LIMIT) begin
         scaled = LO_LIMIT;
      end else begin
         word.saturated = 1'b0;
      end
      word.sample = scaled[SAMPLE_W-1:0];
      return word;
   endfunction

   always @(posedge clock) begin
      filtered_word_type word;
      if (reset) begin
         taps.b0     = UNITY;
         taps.b1     = '0;
         taps.b2     = '0;
         taps.a1     = '0;
         taps.a2     = '0;
         taps.inv_a0 = UNITY;
         x_hist1     = '0;
         x_hist2     = '0;
         y_hist1     = '0;
         y_hist2     = '0;
         expected_words.delete();
         mismatches  = 0;
      end else begin
         // Track coefficient writes; drop unknown indexes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_B0:     taps.b0     = csr_data;
               CSR_B1:     taps.b1     = csr_data;
               CSR_B2:     taps.b2     = csr_data;
               CSR_A1:     taps.a1     = csr_data;
               CSR_A2:     taps.a2     = csr_data;
               CSR_INV_A0: taps.inv_a0 = csr_data;
               default: ;
            endcase
         end

         // Predict each filter word and advance the histories, or clear them
         if (req_valid && req_ready) begin
            if (req_action == ACT_CLEAR) begin
               x_hist1 = '0;
               x_hist2 = '0;
               y_hist1 = '0;
               y_hist2 = '0;
            end else begin
               word = filter_sample(req_sample_in);
               expected_words.push_back(word);
               x_hist2 = x_hist1;
               x_hist1 = req_sample_in;
               y_hist2 = y_hist1;
               y_hist1 = word.sample;
            end
         end

         // Compare each accepted result word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("result word with none outstanding", rsp_sample_out, 0);
            end else begin
               word = expected_words.pop_front();
               if (rsp_sample_out !== word.sample)
                  report_mismatch("sample_out", rsp_sample_out, word.sample);
               if (rsp_saturated !== word.saturated)
                  report_mismatch("saturated", rsp_saturated, word.saturated);
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bqf_pkg::*;

   localparam logic [COEF_W-1:0] UNITY     = COEF_W'(1) << COEF_FRAC;
   localparam logic [COEF_W-1:0] HALF_COEF = COEF_W'(1) << (COEF_FRAC - 1);
   localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
   localparam int DRAIN_CYCLES  = 16;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_WORDS   = 215;
   localparam int TIMEOUT_NS    = 2_000_000;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic                       req_action     = ACT_FILTER;
   logic signed [SAMPLE_W-1:0] req_sample_in  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_saturated;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = CSR_B0;
   logic [COEF_W-1:0]          csr_data       = '0;

   int   pending;
   int   mismatches;
   int   tx_idle_pct   = 28;
   int   rx_idle_pct   = 61;
   logic hold_request  = 1'b0;
   logic hold_done     = 1'b0;
   int   hold_left     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   biquad_iir_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   biquad_output_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pending        (pending),
      .mismatches     (mismatches)
   );

   // Result side: one long hold-off when asked, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Random sample, weighted towards the rails and small values
   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return SAMPLE_W'($urandom_range(511)) - SAMPLE_W'(256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Random coefficient spread over +/- 2^(bits-1)
   function automatic logic [COEF_W-1:0] rand_coef(input int bits);
      if (bits >= COEF_W)
         return COEF_W'($urandom);
      return COEF_W'($urandom_range((32'd1 << bits) - 1)) - (COEF_W'(1) << (bits - 1));
   endfunction

   function automatic logic [COEF_W-1:0] extreme_coef();
      return $urandom_range(1) ? COEF_MAX : COEF_MIN;
   endfunction

   // Offer one request word, idling first at the current rate; return once taken
   task automatic send_word(input logic act, input logic signed [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_sample_in <= smp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Let the filter go idle, then load a full coefficient set
   task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                             input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] inv);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      // an unmapped index must leave every coefficient alone
      write_reg(CSR_IDX_W'($urandom_range(int'(CSR_INV_A0) + 1, (1 << CSR_IDX_W) - 1)),
                COEF_W'($urandom));
      write_reg(CSR_B0, b0);
      write_reg(CSR_B1, b1);
      write_reg(CSR_B2, b2);
      write_reg(CSR_A1, a1);
      write_reg(CSR_A2, a2);
      write_reg(CSR_INV_A0, inv);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int burst_count;
      burst_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients pass samples straight through
      send_word(ACT_FILTER, SAMPLE_MAX);
      send_word(ACT_FILTER, SAMPLE_MIN);
      send_word(ACT_FILTER, '0);
      send_word(ACT_FILTER, SAMPLE_W'(1));
      send_word(ACT_FILTER, -SAMPLE_W'(1));
      send_word(ACT_CLEAR, rand_sample());
      send_word(ACT_FILTER, SAMPLE_MAX);

      // Half gain: rounding ties go towards plus infinity
      load_coefs(HALF_COEF, '0, '0, '0, '0, UNITY);
      send_word(ACT_FILTER, SAMPLE_W'(1));
      send_word(ACT_FILTER, -SAMPLE_W'(1));
      send_word(ACT_FILTER, SAMPLE_W'(3));
      send_word(ACT_FILTER, -SAMPLE_W'(3));

      // Largest positive coefficients: saturate both ways, clear mid-stream
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_word(ACT_FILTER, SAMPLE_MAX);
      send_word(ACT_FILTER, SAMPLE_MIN);
      send_word(ACT_FILTER, '0);
      send_word(ACT_CLEAR, rand_sample());
      send_word(ACT_FILTER, SAMPLE_MIN);
      send_word(ACT_FILTER, SAMPLE_MAX);

      // Most negative coefficients
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_word(ACT_FILTER, SAMPLE_MIN);
      send_word(ACT_FILTER, SAMPLE_MAX);
      send_word(ACT_FILTER, -SAMPLE_W'(1));
      send_word(ACT_FILTER, SAMPLE_W'(1));

      // Random words across several coefficient sets
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: load_coefs(32'sd26843546, 32'sd53687091, 32'sd26843546,
                          -32'sd80530637, 32'sd26843546, UNITY);
            1: load_coefs(rand_coef(28), rand_coef(28), rand_coef(28),
                          rand_coef(28), rand_coef(27), rand_coef(29));
            2: load_coefs(rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W),
                          rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W));
            3: load_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                          extreme_coef(), extreme_coef(), extreme_coef());
            4: load_coefs(rand_coef(27), rand_coef(27), rand_coef(27),
                          rand_coef(26), rand_coef(26), rand_coef(COEF_W));
            default: load_coefs(rand_coef(COEF_W), rand_coef(30), rand_coef(COEF_W),
                                rand_coef(30), rand_coef(COEF_W), rand_coef(30));
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            burst_count++;
            // swap idle rates, then run flat out
            if (burst_count == 420) begin
               tx_idle_pct = 61;
               rx_idle_pct <= 28;
            end
            if (burst_count == 840) begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
            if (burst_count == 250)
               hold_request <= 1'b1;
            if (burst_count == 700)
               drain_results();
            send_word(($urandom_range(99) < 4) ? ACT_CLEAR : ACT_FILTER, rand_sample());
         end
      end

      // Drain, allow for stray late words, then give the verdict
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("biquad_iir_filter regression: pass");
      end else begin
         $display("biquad_iir_filter regression: fail");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("biquad_iir_filter regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bqf_pkg.sv
rtl/core/bqf_csr.sv
rtl/core/bqf_ctrl.sv
rtl/core/bqf_dp.sv
rtl/core/biquad_iir_filter.sv
rtl/core/bqf_checker.sv
sim/biquad_output_checker.sv
sim/tb.sv
